[rtl/rgb_to_i420_converter_assert.svh]
// Assertion macros shared by the converter's checker.
`ifndef RGB_TO_I420_CONVERTER_ASSERT_SVH
`define RGB_TO_I420_CONVERTER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off in reset.
`define RTI_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off in reset.
`define RTI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/rti_pkg.sv]
// Types and constants of the RGB to I420 converter.
`timescale 1ns / 1ps

package rti_pkg;

    localparam int SIZE_W     = 13;
    localparam int ROW_W      = 12;
    localparam int MAX_HEIGHT = 4096;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    localparam logic [SIZE_W-1:0] WIDTH_RESET  = 13'd1920;
    localparam logic [SIZE_W-1:0] HEIGHT_RESET = 13'd1080;

    // Luma coefficients
    localparam logic [15:0] Y_R   = 16'd66;
    localparam logic [15:0] Y_G   = 16'd129;
    localparam logic [15:0] Y_B   = 16'd25;
    localparam logic [15:0] Y_RND = 16'd128;
    localparam logic [7:0]  Y_OFS = 8'd16;

    // Chroma coefficients, magnitudes; offset folds in rounding and +128
    localparam logic signed [17:0] CB_R = 18'sd38;
    localparam logic signed [17:0] CB_G = 18'sd74;
    localparam logic signed [17:0] CB_B = 18'sd112;
    localparam logic signed [17:0] CR_R = 18'sd112;
    localparam logic signed [17:0] CR_G = 18'sd94;
    localparam logic signed [17:0] CR_B = 18'sd18;
    localparam logic signed [17:0] C_OFS = 18'sd32896;

    localparam logic [9:0] AVG_RND = 10'd2;

    typedef enum logic [0:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       frame_start;
    } pixel_t;

    typedef struct packed {
        logic [7:0] luma;
        logic       chroma_valid;
        logic [7:0] chroma_blue;
        logic [7:0] chroma_red;
        logic       frame_end;
    } result_t;

    // Work carried from the accept edge to the conversion stage
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [8:0] sum_red;
        logic [8:0] sum_green;
        logic [8:0] sum_blue;
        logic       chroma;
        logic       frame_end;
    } stage_t;

endpackage

[rtl/rgb_to_i420_converter.sv]
// Top level of the RGB to I420 converter: BT.601 luma per pixel, 4:2:0 chroma.
`timescale 1ns / 1ps
// An accepted pixel passes through the stage register and then the result register.
// Throughput: one pixel per cycle while the result channel is not stalled; the line store takes one access a cycle.
// Pixels outside the even-cropped frame advance position and give no beat.
// Reset: position counters clear, size registers go to 1920 x 1080;
// the line store and held pixel are not cleared and need no clearing pass.
module rgb_to_i420_converter #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // pixel input channel
    input  logic                          pixel_valid,
    output logic                          pixel_ready,
    input  rti_pkg::pixel_t               pixel,
    // result output channel
    output logic                          result_valid,
    input  logic                          result_ready,
    output rti_pkg::result_t              result,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rti_pkg::PADDR_W-1:0]   paddr,
    input  logic [rti_pkg::PDATA_W-1:0]   pwdata,
    output logic [rti_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    // Column counter holds 0..MAX_WIDTH-1; WW holds MAX_WIDTH itself.
    localparam int CW         = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW         = $clog2(MAX_WIDTH + 1);
    localparam int CMPW       = (WW > rti_pkg::SIZE_W) ? WW : rti_pkg::SIZE_W;
    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int LAW        = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int HW         = rti_pkg::SIZE_W;
    localparam int RW         = rti_pkg::ROW_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [rti_pkg::SIZE_W-1:0] frame_width_reg;
    logic [rti_pkg::SIZE_W-1:0] frame_height_reg;
    logic                       cfg_write;
    rti_pkg::reg_idx_t          cfg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = rti_pkg::reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= rti_pkg::WIDTH_RESET;
            frame_height_reg <= rti_pkg::HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                rti_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= pwdata[rti_pkg::SIZE_W-1:0];
                rti_pkg::REG_FRAME_HEIGHT: frame_height_reg <= pwdata[rti_pkg::SIZE_W-1:0];
                default:                   frame_width_reg  <= frame_width_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            rti_pkg::REG_FRAME_WIDTH:  prdata = rti_pkg::PDATA_W'(frame_width_reg);
            rti_pkg::REG_FRAME_HEIGHT: prdata = rti_pkg::PDATA_W'(frame_height_reg);
            default:                   prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Effective frame size: clamp to the legal range, then crop to even.
    // ------------------------------------------------------------------
    logic [CMPW-1:0] width_cmp;
    logic [WW-1:0]   width_eff;
    logic [WW-1:0]   width_crop;
    logic [HW-1:0]   height_eff;
    logic [HW-1:0]   height_crop;

    always_comb
    begin
        width_cmp = CMPW'(frame_width_reg);
        priority if (width_cmp < CMPW'(2))
            width_eff = WW'(2);
        else if (width_cmp > CMPW'(MAX_WIDTH))
            width_eff = WW'(MAX_WIDTH);
        else
            width_eff = WW'(width_cmp);

        priority if (frame_height_reg < HW'(2))
            height_eff = HW'(2);
        else if (frame_height_reg > HW'(rti_pkg::MAX_HEIGHT))
            height_eff = HW'(rti_pkg::MAX_HEIGHT);
        else
            height_eff = frame_height_reg;

        width_crop  = {width_eff[WW-1:1], 1'b0};
        height_crop = {height_eff[HW-1:1], 1'b0};
    end

    // ------------------------------------------------------------------
    // Handshake: a conversion stage and a result register, each one beat.
    // The stage can take a pixel while a finished beat waits downstream; once both are full, pixel_ready drops.
    // ------------------------------------------------------------------
    logic accept;
    logic s1_valid_reg;
    logic s1_valid_next;
    logic s1_adv;
    logic result_valid_reg;
    logic result_valid_next;

    assign s1_adv       = s1_valid_reg && (!result_valid_reg || result_ready);
    assign pixel_ready  = !s1_valid_reg || s1_adv;
    assign accept       = pixel_valid && pixel_ready;
    assign result_valid = result_valid_reg;

    // ------------------------------------------------------------------
    // Position tracking at the accept edge
    // ------------------------------------------------------------------
    logic [CW-1:0]  col_reg;
    logic [CW-1:0]  col_next;
    logic [RW-1:0]  row_reg;
    logic [RW-1:0]  row_next;
    logic [CW-1:0]  col_cur;
    logic [RW-1:0]  row_cur;
    logic [WW-1:0]  col_ext;
    logic [HW-1:0]  row_ext;
    logic           in_frame;
    logic           last_pos;
    logic [LAW-1:0] line_idx;

    always_comb
    begin
        // frame start restarts position before this pixel is placed
        col_cur  = pixel.frame_start ? '0 : col_reg;
        row_cur  = pixel.frame_start ? '0 : row_reg;
        col_ext  = WW'(col_cur);
        row_ext  = HW'(row_cur);
        in_frame = (col_ext < width_crop) && (row_ext < height_crop);
        last_pos = (col_ext == width_crop - WW'(1)) && (row_ext == height_crop - HW'(1));
        line_idx = LAW'(col_cur >> 1);

        // wrap at the effective width, also after the width shrinks
        if (col_ext + WW'(1) >= width_eff)
        begin
            col_next = '0;
            row_next = (row_ext + HW'(1) >= height_eff) ? '0 : row_cur + RW'(1);
        end
        else
        begin
            col_next = col_cur + CW'(1);
            row_next = row_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ------------------------------------------------------------------
    // Held pixel and horizontal pair sums
    // ------------------------------------------------------------------
    logic [23:0] held_reg;
    logic [8:0]  pair_red;
    logic [8:0]  pair_green;
    logic [8:0]  pair_blue;

    always_ff @(posedge clk)
    begin
        // hold the even-column pixel until its partner arrives
        if (accept && in_frame && !col_cur[0])
            held_reg <= {pixel.red, pixel.green, pixel.blue};
    end

    assign pair_red   = 9'(held_reg[23:16]) + 9'(pixel.red);
    assign pair_green = 9'(held_reg[15:8])  + 9'(pixel.green);
    assign pair_blue  = 9'(held_reg[7:0])   + 9'(pixel.blue);

    // ------------------------------------------------------------------
    // Line store of pair sums: even rows write, odd rows read the entry
    // below which they sit. Read data is registered with the accepted beat.
    // ------------------------------------------------------------------
    logic [26:0] line_mem [LINE_DEPTH];
    logic [26:0] line_rd_reg;

    always_ff @(posedge clk)
    begin
        if (accept && in_frame && col_cur[0])
        begin
            if (!row_cur[0])
                line_mem[line_idx] <= {pair_red, pair_green, pair_blue};
            else
                line_rd_reg <= line_mem[line_idx];
        end
    end

    // ------------------------------------------------------------------
    // Conversion stage register
    // ------------------------------------------------------------------
    rti_pkg::stage_t s1_reg;

    always_comb
    begin
        priority if (accept)
            s1_valid_next = in_frame;
        else if (s1_adv)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg.red       <= pixel.red;
            s1_reg.green     <= pixel.green;
            s1_reg.blue      <= pixel.blue;
            s1_reg.sum_red   <= pair_red;
            s1_reg.sum_green <= pair_green;
            s1_reg.sum_blue  <= pair_blue;
            s1_reg.chroma    <= col_cur[0] && row_cur[0];
            s1_reg.frame_end <= last_pos;
        end
    end

    // ------------------------------------------------------------------
    // Color conversion between the stage register and the result register
    // ------------------------------------------------------------------
    logic [15:0]        luma_sum;
    logic [7:0]         avg_red;
    logic [7:0]         avg_green;
    logic [7:0]         avg_blue;
    logic [9:0]         quad_red;
    logic [9:0]         quad_green;
    logic [9:0]         quad_blue;
    logic signed [17:0] cb_sum;
    logic signed [17:0] cr_sum;
    rti_pkg::result_t   result_next;

    always_comb
    begin
        luma_sum = rti_pkg::Y_R * 16'(s1_reg.red) + rti_pkg::Y_G * 16'(s1_reg.green)
                 + rti_pkg::Y_B * 16'(s1_reg.blue) + rti_pkg::Y_RND;

        // 2x2 average with rounding: (sum + 2) / 4
        quad_red   = 10'(line_rd_reg[26:18]) + 10'(s1_reg.sum_red)   + rti_pkg::AVG_RND;
        quad_green = 10'(line_rd_reg[17:9])  + 10'(s1_reg.sum_green) + rti_pkg::AVG_RND;
        quad_blue  = 10'(line_rd_reg[8:0])   + 10'(s1_reg.sum_blue)  + rti_pkg::AVG_RND;
        avg_red    = quad_red[9:2];
        avg_green  = quad_green[9:2];
        avg_blue   = quad_blue[9:2];

        // offset keeps both sums positive, so the high byte is the floor
        cb_sum = rti_pkg::C_OFS
               - rti_pkg::CB_R * $signed(18'(avg_red))
               - rti_pkg::CB_G * $signed(18'(avg_green))
               + rti_pkg::CB_B * $signed(18'(avg_blue));
        cr_sum = rti_pkg::C_OFS
               + rti_pkg::CR_R * $signed(18'(avg_red))
               - rti_pkg::CR_G * $signed(18'(avg_green))
               - rti_pkg::CR_B * $signed(18'(avg_blue));

        result_next.luma         = luma_sum[15:8] + rti_pkg::Y_OFS;
        result_next.chroma_valid = s1_reg.chroma;
        result_next.chroma_blue  = s1_reg.chroma ? cb_sum[15:8] : 8'd0;
        result_next.chroma_red   = s1_reg.chroma ? cr_sum[15:8] : 8'd0;
        result_next.frame_end    = s1_reg.frame_end;
    end

    // ------------------------------------------------------------------
    // Result register: load on advance, drop valid once the beat is taken
    // ------------------------------------------------------------------
    rti_pkg::result_t result_reg;

    always_comb
    begin
        priority if (s1_adv)
            result_valid_next = 1'b1;
        else if (result_ready)
            result_valid_next = 1'b0;
        else
            result_valid_next = result_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else
            result_valid_reg <= result_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
            result_reg <= result_next;
    end

    assign result = result_reg;

endmodule

[rtl/rti_checker.sv]
// Port-level checker of the RGB to I420 converter and its bind.
`timescale 1ns / 1ps
`include "rgb_to_i420_converter_assert.svh"

module rti_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             result_valid,
    input logic             result_ready,
    input rti_pkg::result_t result
);

    // luma stays in the limited range for every 8-bit pixel
    `RTI_ASSERT_NOW(a_luma_range, clk, rst_n, result_valid, (result.luma >= 8'd16) && (result.luma <= 8'd235), "luma outside limited range")

    // chroma fields are zero on beats without a finished 2x2 block
    `RTI_ASSERT_NOW(a_chroma_zero, clk, rst_n, result_valid && !result.chroma_valid, (result.chroma_blue == 8'd0) && (result.chroma_red == 8'd0), "chroma not zero without chroma_valid")

    // the last beat of a cropped frame always closes a 2x2 block
    `RTI_ASSERT_NOW(a_end_has_chroma, clk, rst_n, result_valid && result.frame_end, result.chroma_valid, "frame_end without chroma")

    // a stalled beat holds
    `RTI_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && !result_ready, result_valid && $stable(result), "stalled result beat changed")

endmodule

bind rgb_to_i420_converter rti_checker u_rti_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);
